@@ hdl/windowed_min_path_energy_macros.svh @@
// ----------------------------------------------------------------------------
// windowed_min_path_energy_macros
// assertion macros used by the windowed min path energy rtl
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MIN_PATH_ENERGY_MACROS_SVH
`define WINDOWED_MIN_PATH_ENERGY_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define WMPE_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WMPE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WMPE_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg)
`define WMPE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg)

`endif

`endif

@@ hdl/wmpe_pkg.sv @@
// ----------------------------------------------------------------------------
// wmpe_pkg
// constants, types and helpers of the windowed min path energy block
// ----------------------------------------------------------------------------
`default_nettype none

package wmpe_pkg;

  // column height limit and derived sizes
  localparam int MAX_ROWS   = 1024;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int RAM_AW     = ROW_W + 1;
  localparam int RAM_DEPTH  = 2 ** RAM_AW;

  // field widths
  localparam int ROWS_W     = 11;
  localparam int COLS_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int ENERGY_W   = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_IN_USE = 1'd1;

  // reset values
  localparam int ROWS_RESET      = 1024;
  localparam int COLS_RESET      = 256;
  localparam int ROWS_RESET_LAST = ((ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET) - 1;

  // pipeline stages from accept to result register
  localparam int PIPE_DEPTH = 4;
  // smallest last-row index that keeps the window read clear of in-flight writes
  localparam int FULL_RATE_LAST = PIPE_DEPTH + 1;

  typedef logic [ENERGY_W-1:0] energy_t;
  typedef logic [ROW_W-1:0]    row_t;

  localparam energy_t ENERGY_MAX = '1;

  function automatic energy_t min_energy(energy_t a, energy_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

@@ hdl/wmpe_ram.sv @@
// ----------------------------------------------------------------------------
// wmpe_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module wmpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/windowed_min_path_energy.sv @@
// ----------------------------------------------------------------------------
// windowed_min_path_energy
// streaming cumulative minimum path energy over a column-major gradient map
//
// Gradient samples arrive column by column, rows inner; each sample gives one
// 32-bit saturating energy: the sample itself in column 0, else the sample
// plus the minimum of the previous column over rows r-2..r+2 (clipped at the
// edges). frame_end marks the last row of the last column. The block is a
// four-stage pipeline (window/ram read, two min levels, add and saturate).
// With rows_in_use of 6 or more one sample is taken every cycle while the
// result side is not stalled and no window reload runs. With fewer rows the
// row read from the previous column would still be in the pipeline, so each
// sample waits until stages one to three are empty. The first sample after a
// rows_in_use write that lands in the middle of a column (not column 0) waits
// until stages one to three are empty and the window rows r-2..r+1 are
// reloaded from the column ram. The two column banks share one ram of
// 2 x MAX_ROWS words with one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "windowed_min_path_energy_macros.svh"

module windowed_min_path_energy (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [wmpe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wmpe_pkg::CFG_DATA_W-1:0]    cfg_data,
  // gradient requests
  input  wire logic                               sample_valid,
  output logic                                    sample_ready,
  input  wire logic [wmpe_pkg::SAMPLE_W-1:0]      gradient_sample,
  // energy results
  output logic                                    result_valid,
  input  wire logic                               result_ready,
  output logic [wmpe_pkg::ENERGY_W-1:0]           path_energy,
  output logic                                    frame_end
);

  import wmpe_pkg::*;

  // load sequencer codes
  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_LOAD = 1'b1;

  // configuration, stored as last indexes
  row_t              rows_last;
  row_t              rows_last_next;
  logic [COLS_W-1:0] cols_last;
  logic [COLS_W-1:0] cols_last_next;
  logic [ROWS_W-1:0] rows_raw;
  logic              cfg_rows_wr;
  logic              cfg_cols_wr;
  logic              small_rows;

  // position state
  row_t              row_pos;
  logic [COLS_W-1:0] col_pos;
  logic              bank_select;

  // accept-side decode
  row_t              acc_row;
  logic              acc_end_col;
  logic              acc_end_frame;
  logic              acc_first;
  logic              acc_far_ok;
  logic              accept;
  logic              pipe_empty;
  logic              need_load;
  logic              load_start;

  // load sequencer
  logic              state;
  logic [1:0]        ld_cnt;
  logic              resync;

  // window and column heads
  energy_t           w_win [4];
  logic              far_ok;
  energy_t           head0 [2];
  energy_t           head1 [2];

  // ram ports
  logic              ram_wr_en;
  logic [RAM_AW-1:0] ram_wr_addr;
  energy_t           ram_wr_data;
  logic              ram_rd_en;
  logic [RAM_AW-1:0] ram_rd_addr;
  energy_t           ram_rd_data;
  row_t              rd_row;

  // stage flow
  logic s1_open;
  logic s2_open;
  logic s3_open;
  logic s4_open;

  // stage 1
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_first;
  logic                s1_frame_end;
  row_t                s1_row;
  logic                s1_bank;
  energy_t             s1_w4;

  // stage 2
  logic                s2_valid;
  energy_t             s2_min01;
  energy_t             s2_min23;
  energy_t             s2_w4;
  logic [SAMPLE_W-1:0] s2_sample;
  logic                s2_first;
  logic                s2_frame_end;
  row_t                s2_row;
  logic                s2_bank;

  // stage 3
  logic                s3_valid;
  energy_t             s3_min;
  energy_t             s3_w4;
  logic [SAMPLE_W-1:0] s3_sample;
  logic                s3_first;
  logic                s3_frame_end;
  row_t                s3_row;
  logic                s3_bank;
  energy_t             s3_best;
  logic [ENERGY_W:0]   s3_sum;
  energy_t             s3_energy;

  // configuration decode, out-of-range values clamped on write
  assign cfg_ready   = 1'b1;
  assign rows_raw    = cfg_data[ROWS_W-1:0];
  assign cfg_rows_wr = cfg_valid && (cfg_index == CFG_ROWS_IN_USE);
  assign cfg_cols_wr = cfg_valid && (cfg_index == CFG_COLUMNS_IN_USE);

  always_comb begin
    if (rows_raw == '0) begin
      rows_last_next = '0;
    end else if (int'(rows_raw) > MAX_ROWS) begin
      rows_last_next = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_last_next = ROW_W'(rows_raw - 1'b1);
    end
    if (cfg_data[COLS_W-1:0] == '0) begin
      cols_last_next = '0;
    end else begin
      cols_last_next = cfg_data[COLS_W-1:0] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_last <= ROW_W'(ROWS_RESET_LAST);
      cols_last <= COLS_W'(COLS_RESET - 1);
    end else begin
      if (cfg_rows_wr) begin
        rows_last <= rows_last_next;
      end
      if (cfg_cols_wr) begin
        cols_last <= cols_last_next;
      end
    end
  end

  assign small_rows = (rows_last < ROW_W'(FULL_RATE_LAST));

  // row clamp, column end and frame end for the waiting request
  always_comb begin
    acc_row       = (row_pos > rows_last) ? rows_last : row_pos;
    acc_end_col   = (acc_row == rows_last);
    acc_end_frame = acc_end_col && (col_pos >= cols_last);
    acc_first     = (col_pos == '0);
    acc_far_ok    = ((ROW_W+1)'(acc_row) + (ROW_W+1)'(2)) <= (ROW_W+1)'(rows_last);
  end

  // handshake and interlocks
  assign s4_open = !result_valid || result_ready;
  assign s3_open = !s3_valid || s4_open;
  assign s2_open = !s2_valid || s3_open;
  assign s1_open = !s1_valid || s2_open;

  assign pipe_empty   = !s1_valid && !s2_valid && !s3_valid;
  assign need_load    = resync && (acc_row != '0) && !acc_first;
  assign sample_ready = s1_open && (state == ST_RUN) && !need_load &&
                        !(small_rows && !pipe_empty);
  assign accept       = sample_valid && sample_ready;
  assign load_start   = (state == ST_RUN) && sample_valid && need_load && pipe_empty;

  // row, column and bank counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos     <= '0;
      col_pos     <= '0;
      bank_select <= 1'b0;
    end else if (accept) begin
      if (acc_end_col) begin
        row_pos     <= '0;
        bank_select <= ~bank_select;
        if (acc_end_frame) begin
          col_pos <= '0;
        end else begin
          col_pos <= col_pos + 1'b1;
        end
      end else begin
        row_pos <= acc_row + 1'b1;
      end
    end
  end

  // window reload sequencer after a row count change
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_RUN;
      ld_cnt <= '0;
      resync <= 1'b0;
    end else if (cfg_rows_wr) begin
      state  <= ST_RUN;
      resync <= 1'b1;
    end else begin
      case (state)
        ST_RUN: begin
          if (load_start) begin
            state  <= ST_LOAD;
            ld_cnt <= '0;
          end
          if (accept) begin
            resync <= 1'b0;
          end
        end
        ST_LOAD: begin
          ld_cnt <= ld_cnt + 1'b1;
          if (ld_cnt == 2'd3) begin
            state  <= ST_RUN;
            resync <= 1'b0;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // ram read: row r+2 on accept, rows r-2..r+1 while reloading
  always_comb begin
    if (state == ST_LOAD) begin
      rd_row = ROW_W'(acc_row + ROW_W'(ld_cnt) - ROW_W'(2));
    end else begin
      rd_row = ROW_W'(acc_row + ROW_W'(2));
    end
    ram_rd_en   = accept || (state == ST_LOAD);
    ram_rd_addr = {bank_select, rd_row};
  end

  // sliding window over rows r-2..r+1, the row r+2 word sits in the ram output
  always_ff @(posedge clk) begin
    if (rst) begin
      far_ok <= 1'b0;
    end else if (accept) begin
      if (acc_row == '0) begin
        w_win[0] <= ENERGY_MAX;
        w_win[1] <= ENERGY_MAX;
        w_win[2] <= head0[bank_select];
        w_win[3] <= (rows_last != '0) ? head1[bank_select] : ENERGY_MAX;
      end else begin
        w_win[0] <= w_win[1];
        w_win[1] <= w_win[2];
        w_win[2] <= w_win[3];
        w_win[3] <= far_ok ? ram_rd_data : ENERGY_MAX;
      end
      far_ok <= acc_far_ok;
    end else if (state == ST_LOAD) begin
      // loaded one row early so that the shift on accept lines up
      case (ld_cnt)
        2'd1: begin
          w_win[1] <= (acc_row > ROW_W'(1)) ? ram_rd_data : ENERGY_MAX;
        end
        2'd2: begin
          w_win[2] <= ram_rd_data;
        end
        2'd3: begin
          w_win[3] <= ram_rd_data;
          far_ok   <= (acc_row != rows_last);
        end
        default: begin
        end
      endcase
    end
  end

  // stage 1: request fields
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_open) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample    <= gradient_sample;
      s1_first     <= acc_first;
      s1_frame_end <= acc_end_frame;
      s1_row       <= acc_row;
      s1_bank      <= ~bank_select;
    end
  end

  assign s1_w4 = far_ok ? ram_rd_data : ENERGY_MAX;

  // stage 2: first min level
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_open) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_open) begin
      s2_min01     <= min_energy(w_win[0], w_win[1]);
      s2_min23     <= min_energy(w_win[2], w_win[3]);
      s2_w4        <= s1_w4;
      s2_sample    <= s1_sample;
      s2_first     <= s1_first;
      s2_frame_end <= s1_frame_end;
      s2_row       <= s1_row;
      s2_bank      <= s1_bank;
    end
  end

  // stage 3: second min level
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_open) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_open) begin
      s3_min       <= min_energy(s2_min01, s2_min23);
      s3_w4        <= s2_w4;
      s3_sample    <= s2_sample;
      s3_first     <= s2_first;
      s3_frame_end <= s2_frame_end;
      s3_row       <= s2_row;
      s3_bank      <= s2_bank;
    end
  end

  // final min, add and saturate, the sample alone in column 0
  always_comb begin
    s3_best = min_energy(s3_min, s3_w4);
    s3_sum  = {1'b0, s3_best} + (ENERGY_W+1)'(s3_sample);
    if (s3_first) begin
      s3_energy = ENERGY_W'(s3_sample);
    end else if (s3_sum[ENERGY_W]) begin
      s3_energy = ENERGY_MAX;
    end else begin
      s3_energy = s3_sum[ENERGY_W-1:0];
    end
  end

  // stage 4: result register and column write
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s4_open) begin
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_open) begin
      path_energy <= s3_energy;
      frame_end   <= s3_frame_end;
    end
  end

  assign ram_wr_en   = s4_open && s3_valid;
  assign ram_wr_addr = {s3_bank, s3_row};
  assign ram_wr_data = s3_energy;

  // rows 0 and 1 of each bank kept aside for the column start
  always_ff @(posedge clk) begin
    if (ram_wr_en && (s3_row == ROW_W'(0))) begin
      head0[s3_bank] <= s3_energy;
    end
    if (ram_wr_en && (s3_row == ROW_W'(1))) begin
      head1[s3_bank] <= s3_energy;
    end
  end

  wmpe_ram #(
    .WIDTH(ENERGY_W),
    .DEPTH(RAM_DEPTH)
  ) u_col_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // checks
  `WMPE_ASSERT_NOW(a_load_blocks_accept, clk, rst, state == ST_LOAD, !sample_ready, "request taken during window reload")
  `WMPE_ASSERT_NOW(a_load_pipe_empty, clk, rst, state == ST_LOAD, pipe_empty, "window reload with requests in flight")
  `WMPE_ASSERT_NOW(a_small_rows_drained, clk, rst, accept && small_rows, pipe_empty, "short column request taken over in-flight writes")
  `WMPE_ASSERT_NEXT(a_accept_enters_s1, clk, rst, accept, s1_valid, "accepted request missing from stage 1")
  `WMPE_ASSERT_NOW(a_load_only_midcolumn, clk, rst, state == ST_LOAD, (acc_row != '0) && !acc_first, "window reload outside a mid-column row")

endmodule

`default_nettype wire
